### src/trfe_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// trfe_pkg
// Shared types and constants for the tristate remote frame encoder.
// ============================================================================
package trfe_pkg;

    // Phase counter width; durations are taken in their low TICK_BITS bits.
    localparam int TICK_BITS   = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 8;
    localparam int REPEAT_W    = 8;
    localparam int POS_W       = 4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_TICKS    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_TICKS     = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_LOW_TICKS = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_COUNT   = CFG_INDEX_W'(3);

    localparam logic [CFG_DATA_W-1:0] SHORT_TICKS_RST    = CFG_DATA_W'(350);
    localparam logic [CFG_DATA_W-1:0] LONG_TICKS_RST     = CFG_DATA_W'(1050);
    localparam logic [CFG_DATA_W-1:0] SYNC_LOW_TICKS_RST = CFG_DATA_W'(11200);
    localparam logic [REPEAT_W-1:0]   REPEAT_COUNT_RST   = REPEAT_W'(10);

    // Command opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Symbol codes
    typedef enum logic [1:0] {
        SYM_ZERO = 2'd0,
        SYM_ONE  = 2'd1,
        SYM_TWO  = 2'd2,
        SYM_SYNC = 2'd3
    } sym_t;

    // Frame positions
    localparam logic [POS_W-1:0] POS_FIRST_OBJECT = POS_W'(4);
    localparam logic [POS_W-1:0] POS_FIXED_ZERO   = POS_W'(7);
    localparam logic [POS_W-1:0] POS_ACTIVATION   = POS_W'(11);
    localparam logic [POS_W-1:0] POS_SYNC         = POS_W'(12);
    localparam logic [POS_W-1:0] POS_END          = POS_W'(13);

    localparam logic [1:0] OBJECT_NONE    = 2'd0;
    localparam logic [1:0] ACTIVATION_NONE = 2'd3;

    typedef struct packed {
        logic       opcode;
        logic [1:0] house;
        logic [1:0] object;
        logic [1:0] activation;
    } cmd_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic burst_done;
    } rsp_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] short_ticks;
        logic [CFG_DATA_W-1:0] long_ticks;
        logic [CFG_DATA_W-1:0] sync_low_ticks;
        logic [REPEAT_W-1:0]   repeat_count;
    } cfg_t;

endpackage

### src/trfe_if.sv
`timescale 1ns / 1ps
// ============================================================================
// trfe_if
// Valid/ready channels for commands and line results.
// ============================================================================
interface trfe_cmd_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [1:0] house;
    logic [1:0] object;
    logic [1:0] activation;

    modport source (output valid, opcode, house, object, activation, input ready);
    modport sink   (input valid, opcode, house, object, activation, output ready);
endinterface

interface trfe_rsp_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic burst_done;

    modport source (output valid, line_level, busy_res, burst_done, input ready);
    modport sink   (input valid, line_level, busy_res, burst_done, output ready);
endinterface

### src/tristate_remote_frame_encoder_unit.sv
`timescale 1ns / 1ps
// A command accepted into the command register reaches rsp through the result register.
// Throughput: one command per clock; the command register and result register
// stream with full back-pressure, limited only by the rsp sink.
// Reset (rst_n, async, active low): idle, line low, config at default timing
// (350/1050/11200 ticks, 10 repeats); no clearing pass.
// ============================================================================
// tristate_remote_frame_encoder_unit
// Tristate remote frame encoder: start/tick commands in, line level out.
// ============================================================================
module tristate_remote_frame_encoder_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [trfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [trfe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    trfe_cmd_if.sink                         cmd,
    trfe_rsp_if.source                       rsp
);
    import trfe_pkg::*;

    // Command register: one transaction captured per cycle while cmd.ready is high.
    logic  cmd_valid_reg, cmd_valid_next;
    cmd_t  cmd_reg,       cmd_next;

    // Result register feeding the rsp channel.
    logic  rsp_valid_reg, rsp_valid_next;
    rsp_t  rsp_reg,       rsp_next;

    cfg_t  cfg;
    rsp_t  core_rsp;
    logic  step;      // command register moves into the result register
    logic  cmd_take;  // cmd transaction this cycle

    trfe_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    trfe_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cmd   (cmd_reg),
        .cfg   (cfg),
        .rsp   (core_rsp)
    );

    // The result slot frees when rsp is taken, so both stages advance together.
    assign step      = cmd_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign cmd.ready = !cmd_valid_reg || step;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        if (cmd_take)
        begin
            cmd_valid_next    = 1'b1;
            cmd_next.opcode     = cmd.opcode;
            cmd_next.house      = cmd.house;
            cmd_next.object     = cmd.object;
            cmd_next.activation = cmd.activation;
        end
        else if (step)
        begin
            cmd_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (step)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = core_rsp;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rsp_reg <= rsp_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.line_level = rsp_reg.line_level;
    assign rsp.busy_res   = rsp_reg.busy_res;
    assign rsp.burst_done = rsp_reg.burst_done;

endmodule

### src/trfe_cfg_regs.sv
`timescale 1ns / 1ps
// ============================================================================
// trfe_cfg_regs
// Timing and repeat configuration registers, write only.
// ============================================================================
module trfe_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [trfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [trfe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output trfe_pkg::cfg_t                  cfg
);
    import trfe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHORT_TICKS:    cfg_next.short_ticks    = cfg_wdata;
                REG_LONG_TICKS:     cfg_next.long_ticks     = cfg_wdata;
                REG_SYNC_LOW_TICKS: cfg_next.sync_low_ticks = cfg_wdata;
                REG_REPEAT_COUNT:   cfg_next.repeat_count   = cfg_wdata[REPEAT_W-1:0];
                default:            cfg_next = cfg_reg; // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_ticks    <= SHORT_TICKS_RST;
            cfg_reg.long_ticks     <= LONG_TICKS_RST;
            cfg_reg.sync_low_ticks <= SYNC_LOW_TICKS_RST;
            cfg_reg.repeat_count   <= REPEAT_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/trfe_core.sv
`timescale 1ns / 1ps
// ============================================================================
// trfe_core
// Frame sequencer: symbol position, pulse phase and tick counter.
// ============================================================================
module trfe_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,     // process cmd this cycle
    input  trfe_pkg::cmd_t cmd,
    input  trfe_pkg::cfg_t cfg,
    output trfe_pkg::rsp_t rsp
);
    import trfe_pkg::*;

    logic                  active_reg,       active_next;
    logic [REPEAT_W-1:0]   repeats_left_reg, repeats_left_next;
    logic [POS_W-1:0]      symbol_pos_reg,   symbol_pos_next;
    logic                  second_pulse_reg, second_pulse_next;
    logic                  high_phase_reg,   high_phase_next;
    logic [TICK_BITS-1:0]  phase_ticks_reg,  phase_ticks_next;
    logic [1:0]            held_house_reg,   held_house_next;
    logic [1:0]            held_object_reg,  held_object_next;
    logic [1:0]            held_act_reg,     held_act_next;

    sym_t                  sym;
    logic                  long_high;
    logic [CFG_DATA_W-1:0] dur_raw;
    logic [TICK_BITS-1:0]  dur;
    logic [TICK_BITS:0]    ticks_inc;
    logic                  phase_over;
    logic [POS_W-1:0]      pos_inc;
    logic [REPEAT_W-1:0]   repeats_dec;
    logic                  done;

    function automatic sym_t symbol_at(input logic [POS_W-1:0] pos,
                                       input logic [1:0] house,
                                       input logic [1:0] object,
                                       input logic [1:0] act);
        sym_t s;
        if (pos < POS_FIRST_OBJECT)
            s = (POS_W'(house) == pos) ? SYM_ONE : SYM_ZERO;
        else if (pos < POS_FIXED_ZERO)
            s = ((POS_W'(object) + POS_W'(3)) == pos) ? SYM_ONE : SYM_ZERO;
        else if (pos == POS_FIXED_ZERO)
            s = SYM_ZERO;
        else if (pos < POS_ACTIVATION)
            s = SYM_ONE;
        else if (pos == POS_ACTIVATION)
            s = sym_t'(act);
        else
            s = SYM_SYNC;
        return s;
    endfunction

    // Phase length lookup, next symbol position and repeat decrement
    always_comb
    begin
        sym = symbol_at(symbol_pos_reg, held_house_reg, held_object_reg, held_act_reg);
        long_high = (sym == SYM_ZERO) ? second_pulse_reg : (sym == SYM_TWO);
        if (sym == SYM_SYNC)
            dur_raw = high_phase_reg ? cfg.short_ticks : cfg.sync_low_ticks;
        else if (high_phase_reg)
            dur_raw = long_high ? cfg.long_ticks : cfg.short_ticks;
        else
            dur_raw = long_high ? cfg.short_ticks : cfg.long_ticks;
        dur = TICK_BITS'(dur_raw);
        if (dur == '0)
            dur = TICK_BITS'(1);
        ticks_inc  = {1'b0, phase_ticks_reg} + (TICK_BITS+1)'(1);
        phase_over = (ticks_inc >= {1'b0, dur});
        pos_inc    = symbol_pos_reg + POS_W'(1);
        if (pos_inc == POS_FIRST_OBJECT && held_object_reg == OBJECT_NONE)
            pos_inc = POS_FIXED_ZERO;
        if (pos_inc == POS_ACTIVATION && held_act_reg == ACTIVATION_NONE)
            pos_inc = POS_SYNC;
        repeats_dec = repeats_left_reg - REPEAT_W'(1);
    end

    // Next state
    always_comb
    begin
        active_next       = active_reg;
        repeats_left_next = repeats_left_reg;
        symbol_pos_next   = symbol_pos_reg;
        second_pulse_next = second_pulse_reg;
        high_phase_next   = high_phase_reg;
        phase_ticks_next  = phase_ticks_reg;
        held_house_next   = held_house_reg;
        held_object_next  = held_object_reg;
        held_act_next     = held_act_reg;
        done              = 1'b0;

        if (step)
        begin
            if (cmd.opcode == OP_START)
            begin
                if (!active_reg && cfg.repeat_count != '0)
                begin
                    held_house_next   = cmd.house;
                    held_object_next  = cmd.object;
                    held_act_next     = cmd.activation;
                    repeats_left_next = cfg.repeat_count;
                    symbol_pos_next   = '0;
                    second_pulse_next = 1'b0;
                    high_phase_next   = 1'b1;
                    phase_ticks_next  = '0;
                    active_next       = 1'b1;
                end
            end
            else if (active_reg)
            begin
                if (!phase_over)
                begin
                    phase_ticks_next = ticks_inc[TICK_BITS-1:0];
                end
                else
                begin
                    phase_ticks_next = '0;
                    if (high_phase_reg)
                    begin
                        high_phase_next = 1'b0;
                    end
                    else if (sym != SYM_SYNC && !second_pulse_reg)
                    begin
                        second_pulse_next = 1'b1;
                        high_phase_next   = 1'b1;
                    end
                    else
                    begin
                        second_pulse_next = 1'b0;
                        high_phase_next   = 1'b1;
                        if (pos_inc >= POS_END)
                        begin
                            symbol_pos_next   = '0;
                            repeats_left_next = repeats_dec;
                            if (repeats_dec == '0)
                            begin
                                active_next     = 1'b0;
                                high_phase_next = 1'b0;
                                done            = 1'b1;
                            end
                        end
                        else
                        begin
                            symbol_pos_next = pos_inc;
                        end
                    end
                end
            end
        end
    end

    // Result: a start shows the state after it, a tick the phase it ran in
    always_comb
    begin
        if (cmd.opcode == OP_START)
        begin
            rsp.line_level = active_next & high_phase_next;
            rsp.busy_res   = active_next;
        end
        else
        begin
            rsp.line_level = active_reg & high_phase_reg;
            rsp.busy_res   = active_reg;
        end
        rsp.burst_done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            repeats_left_reg <= '0;
            symbol_pos_reg   <= '0;
            second_pulse_reg <= 1'b0;
            high_phase_reg   <= 1'b0;
            phase_ticks_reg  <= '0;
            held_house_reg   <= '0;
            held_object_reg  <= '0;
            held_act_reg     <= '0;
        end
        else
        begin
            active_reg       <= active_next;
            repeats_left_reg <= repeats_left_next;
            symbol_pos_reg   <= symbol_pos_next;
            second_pulse_reg <= second_pulse_next;
            high_phase_reg   <= high_phase_next;
            phase_ticks_reg  <= phase_ticks_next;
            held_house_reg   <= held_house_next;
            held_object_reg  <= held_object_next;
            held_act_reg     <= held_act_next;
        end
    end

    a_done_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !active_reg && !high_phase_reg)
        else $error("burst_done without returning to idle");

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_pos_reg < POS_END)
        else $error("symbol position past end of frame");

    a_idle_line_low: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> !high_phase_reg)
        else $error("high phase while idle");

    a_active_has_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> repeats_left_reg != '0)
        else $error("active burst with no repeats left");

    a_start_holds_burst: assert property (@(posedge clk) disable iff (!rst_n)
        step && active_reg && cmd.opcode == OP_START
        |=> active_reg && $stable(held_house_reg) && $stable(held_object_reg))
        else $error("start while busy disturbed the burst");

endmodule

### tb/sv/tristate_remote_frame_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tristate_remote_frame_encoder_unit_tb
// Self-checking bench for the tristate remote frame encoder. A short table of
// directed transactions hits reset state, zero and all-ones register values,
// ignored starts and a two-frame burst. Random start/tick traffic then runs
// under several register settings and handshake idling modes. Every line
// result is checked field by field against a cycle-free frame predictor.
// ============================================================================
module tristate_remote_frame_encoder_unit_tb;
    import trfe_pkg::*;

    localparam int HANG_LIMIT     = 2000;  // cycles with no transaction on either side
    localparam int SETTLE_CYCLES  = 8;     // idle time after the last result comes back, as slack
    localparam int RANDOM_TARGET  = 1050;
    localparam int SUBPHASES      = 8;
    localparam int MAX_PRINTS     = 40;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = CFG_INDEX_W'(255);
    localparam logic [CFG_DATA_W-1:0]  DATA_ONES    = '1;
    localparam logic [CFG_DATA_W-1:0]  DATA_ZERO    = '0;

    // result shorthands for the directed table: {line_level, busy_res, burst_done}
    localparam rsp_t RSP_IDLE      = rsp_t'(3'b000);
    localparam rsp_t RSP_HIGH_BUSY = rsp_t'(3'b110);

    typedef enum logic [1:0] {
        ROW_ITEM,   // one command transaction
        ROW_CFG,    // register write, taken once the pipeline is empty
        ROW_FLUSH   // tick until the running burst has ended
    } row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        cmd_t                   cmd;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_data;
        logic                   typed;   // want holds a hand-written result
        rsp_t                   want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    trfe_cmd_if cmd_ch ();
    trfe_rsp_if rsp_ch ();

    tristate_remote_frame_encoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Frame predictor: shadow registers and encoder state
    // ------------------------------------------------------------------------
    cfg_t                 regs;
    logic                 enc_active;
    logic [REPEAT_W-1:0]  frames_left;
    logic [POS_W-1:0]     slot;
    logic                 in_second_pulse;
    logic                 in_high;
    logic [TICK_BITS-1:0] ticks_spent;
    logic [1:0]           house_q;
    logic [1:0]           object_q;
    logic [1:0]           activation_q;

    rsp_t line_q [$];   // expected line results, oldest first

    int  errors        = 0;
    int  items_sent    = 0;
    int  writes_done   = 0;
    int  bursts_seen   = 0;
    int  quiet_cycles  = 0;
    int  send_idle_pct = 0;
    int  stall_pct     = 0;

    // Symbol sent at a frame position for the latched house/object/activation.
    function automatic sym_t symbol_at_slot(logic [POS_W-1:0] pos);
        if (pos < POS_FIRST_OBJECT)
            return (POS_W'(house_q) == pos) ? SYM_ONE : SYM_ZERO;
        if (pos < POS_FIXED_ZERO)
            return (POS_W'(object_q) == pos - POS_FIRST_OBJECT + POS_W'(1)) ? SYM_ONE : SYM_ZERO;
        if (pos == POS_FIXED_ZERO)
            return SYM_ZERO;
        if (pos < POS_ACTIVATION)
            return SYM_ONE;
        if (pos == POS_ACTIVATION)
            return sym_t'(activation_q);
        return SYM_SYNC;
    endfunction

    // zero-length phases still last one tick
    function automatic logic [TICK_BITS-1:0] at_least_one(logic [TICK_BITS-1:0] v);
        return (v == '0) ? TICK_BITS'(1) : v;
    endfunction

    function automatic logic [TICK_BITS-1:0] phase_length();
        sym_t sym;
        logic long_high;
        sym = symbol_at_slot(slot);
        if (sym == SYM_SYNC)
            return at_least_one(in_high ? regs.short_ticks : regs.sync_low_ticks);
        // symbol 0 is short-high then long-high; 2 is long-high twice; 1 short twice
        long_high = (sym == SYM_ZERO) ? in_second_pulse : (sym == SYM_TWO);
        if (in_high)
            return at_least_one(long_high ? regs.long_ticks : regs.short_ticks);
        return at_least_one(long_high ? regs.short_ticks : regs.long_ticks);
    endfunction

    function automatic logic [POS_W-1:0] following_slot(logic [POS_W-1:0] pos);
        logic [POS_W-1:0] p;
        p = pos + POS_W'(1);
        if (p == POS_FIRST_OBJECT && object_q == OBJECT_NONE)
            p = POS_FIXED_ZERO;
        if (p == POS_ACTIVATION && activation_q == ACTIVATION_NONE)
            p = POS_SYNC;
        return p;
    endfunction

    // Close the current phase; returns 1 when the last frame of the burst ends.
    function automatic logic close_phase();
        ticks_spent = '0;
        if (in_high)
        begin
            in_high = 1'b0;
            return 1'b0;
        end
        if (symbol_at_slot(slot) != SYM_SYNC && !in_second_pulse)
        begin
            in_second_pulse = 1'b1;
            in_high = 1'b1;
            return 1'b0;
        end
        in_second_pulse = 1'b0;
        in_high = 1'b1;
        slot = following_slot(slot);
        if (slot >= POS_END)
        begin
            slot = '0;
            frames_left = frames_left - 1'b1;
            if (frames_left == '0)
            begin
                enc_active = 1'b0;
                in_high = 1'b0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic rsp_t predict_line(cmd_t c);
        rsp_t r;
        r = RSP_IDLE;
        if (c.opcode == OP_START)
        begin
            // a start while busy, or with a zero repeat count, changes nothing
            if (!enc_active && regs.repeat_count != '0)
            begin
                house_q = c.house;
                object_q = c.object;
                activation_q = c.activation;
                frames_left = regs.repeat_count;
                slot = '0;
                in_second_pulse = 1'b0;
                in_high = 1'b1;
                ticks_spent = '0;
                enc_active = 1'b1;
            end
            r.line_level = enc_active & in_high;
            r.busy_res = enc_active;
        end
        else if (enc_active)
        begin
            // level reported is the one held during this tick
            r.line_level = in_high;
            r.busy_res = 1'b1;
            if ({1'b0, ticks_spent} + (TICK_BITS+1)'(1) >= {1'b0, phase_length()})
                r.burst_done = close_phase();
            else
                ticks_spent = ticks_spent + 1'b1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what);
        if (errors < MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, what);
        errors++;
    endtask

    always @(posedge clk)
    begin : line_check
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (line_q.size() == 0)
                report_mismatch("line result with no pending transaction");
            else
            begin
                want = line_q.pop_front();
                if (rsp_ch.line_level !== want.line_level)
                    report_mismatch($sformatf("line_level %b, wanted %b",
                                              rsp_ch.line_level, want.line_level));
                if (rsp_ch.busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy_res %b, wanted %b",
                                              rsp_ch.busy_res, want.busy_res));
                if (rsp_ch.burst_done !== want.burst_done)
                    report_mismatch($sformatf("burst_done %b, wanted %b",
                                              rsp_ch.burst_done, want.burst_done));
                if (want.burst_done)
                    bursts_seen++;
            end
        end
    end

    // Hang detection: no transaction on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("Timeout: %0d cycles without a transaction, %0d results pending",
                     HANG_LIMIT, line_q.size());
            $display("tristate_remote_frame_encoder_unit: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result back-pressure; stall_pct set per phase by the sequencer.
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

    // ------------------------------------------------------------------------
    // Drivers (all called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------------
    function automatic cmd_t mk_cmd(logic op, logic [1:0] h, logic [1:0] o, logic [1:0] a);
        cmd_t c;
        c.opcode = op;
        c.house = h;
        c.object = o;
        c.activation = a;
        return c;
    endfunction

    function automatic stim_row_t item_row(logic op, logic [1:0] h, logic [1:0] o,
                                           logic [1:0] a, logic typed, rsp_t want);
        stim_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.cmd = mk_cmd(op, h, o, a);
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_index = idx;
        r.reg_data = data;
        return r;
    endfunction

    // One command transaction. Valid stays high between back-to-back commands.
    task automatic push_cmd(cmd_t c, logic typed, rsp_t want);
        rsp_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.opcode <= c.opcode;
        cmd_ch.house <= c.house;
        cmd_ch.object <= c.object;
        cmd_ch.activation <= c.activation;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        // predictor always steps; typed rows override its result
        predicted = predict_line(c);
        line_q.push_back(typed ? want : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic tick_until_idle();
        while (enc_active)
            push_cmd(mk_cmd(OP_TICK, 2'($urandom), 2'($urandom), 2'($urandom)), 1'b0, RSP_IDLE);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (line_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_SHORT_TICKS:    regs.short_ticks = data;
            REG_LONG_TICKS:     regs.long_ticks = data;
            REG_SYNC_LOW_TICKS: regs.sync_low_ticks = data;
            REG_REPEAT_COUNT:   regs.repeat_count = data[REPEAT_W-1:0];
            default: ;   // unmapped index: no effect
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        writes_done++;
    endtask

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    initial
    begin
        stim_row_t directed [$];
        cmd_t      c;
        int        counted;
        logic      was_active;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = OP_TICK;
        cmd_ch.house = '0;
        cmd_ch.object = '0;
        cmd_ch.activation = '0;
        rsp_ch.ready = 1'b0;

        regs.short_ticks = SHORT_TICKS_RST;
        regs.long_ticks = LONG_TICKS_RST;
        regs.sync_low_ticks = SYNC_LOW_TICKS_RST;
        regs.repeat_count = REPEAT_COUNT_RST;
        enc_active = 1'b0;
        frames_left = '0;
        slot = '0;
        in_second_pulse = 1'b0;
        in_high = 1'b0;
        ticks_spent = '0;
        house_q = '0;
        object_q = '0;
        activation_q = '0;

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed table ---
        // idle tick straight out of reset
        directed.push_back(item_row(OP_TICK, 2'd0, 2'd0, 2'd0, 1'b1, RSP_IDLE));
        // zero repeat count: start ignored, block stays idle
        directed.push_back(cfg_row(REG_REPEAT_COUNT, DATA_ZERO));
        directed.push_back(item_row(OP_START, 2'd3, 2'd3, 2'd3, 1'b1, RSP_IDLE));
        directed.push_back(item_row(OP_TICK, 2'd3, 2'd3, 2'd3, 1'b1, RSP_IDLE));
        // unmapped index, then all-ones timing; two frames per burst
        directed.push_back(cfg_row(REG_UNMAPPED, DATA_ONES));
        directed.push_back(cfg_row(REG_SHORT_TICKS, DATA_ONES));
        directed.push_back(cfg_row(REG_LONG_TICKS, DATA_ONES));
        directed.push_back(cfg_row(REG_SYNC_LOW_TICKS, DATA_ONES));
        directed.push_back(cfg_row(REG_REPEAT_COUNT, CFG_DATA_W'(2)));
        // start from idle, then a start while busy that must be ignored
        directed.push_back(item_row(OP_START, 2'd3, 2'd0, 2'd3, 1'b1, RSP_HIGH_BUSY));
        directed.push_back(item_row(OP_START, 2'd0, 2'd3, 2'd2, 1'b1, RSP_HIGH_BUSY));
        // first short-high phase is now a million ticks long
        directed.push_back(item_row(OP_TICK, 2'd0, 2'd0, 2'd0, 1'b1, RSP_HIGH_BUSY));
        directed.push_back(item_row(OP_TICK, 2'd1, 2'd1, 2'd1, 1'b1, RSP_HIGH_BUSY));
        directed.push_back(item_row(OP_TICK, 2'd2, 2'd2, 2'd2, 1'b1, RSP_HIGH_BUSY));
        // shrink to zero mid-burst: every phase collapses to one tick
        directed.push_back(cfg_row(REG_SHORT_TICKS, DATA_ZERO));
        directed.push_back(cfg_row(REG_LONG_TICKS, DATA_ZERO));
        directed.push_back(cfg_row(REG_SYNC_LOW_TICKS, DATA_ZERO));
        directed.push_back(item_row(OP_TICK, 2'd0, 2'd0, 2'd0, 1'b1, RSP_HIGH_BUSY));
        directed.push_back(item_row(OP_TICK, 2'd0, 2'd0, 2'd0, 1'b0, RSP_IDLE));
        directed.push_back(item_row(OP_START, 2'd1, 2'd2, 2'd1, 1'b0, RSP_IDLE));
        directed.push_back(item_row(OP_TICK, 2'd0, 2'd0, 2'd0, 1'b0, RSP_IDLE));
        // run out both frames (no object symbols, no activation symbol)
        directed.push_back('{kind: ROW_FLUSH, default: '0});
        directed.push_back(item_row(OP_TICK, 2'd0, 2'd0, 2'd0, 1'b1, RSP_IDLE));
        // single-frame bursts that between them send every symbol type
        directed.push_back(cfg_row(REG_REPEAT_COUNT, CFG_DATA_W'(1)));
        directed.push_back(cfg_row(REG_SHORT_TICKS, CFG_DATA_W'(1)));
        directed.push_back(cfg_row(REG_LONG_TICKS, CFG_DATA_W'(2)));
        directed.push_back(cfg_row(REG_SYNC_LOW_TICKS, CFG_DATA_W'(3)));
        directed.push_back(item_row(OP_START, 2'd0, 2'd1, 2'd0, 1'b0, RSP_IDLE));
        directed.push_back('{kind: ROW_FLUSH, default: '0});
        directed.push_back(item_row(OP_START, 2'd2, 2'd3, 2'd2, 1'b0, RSP_IDLE));
        directed.push_back('{kind: ROW_FLUSH, default: '0});

        foreach (directed[i])
        begin
            case (directed[i].kind)
                ROW_ITEM:
                    push_cmd(directed[i].cmd, directed[i].typed, directed[i].want);
                ROW_CFG:
                begin
                    settle();
                    write_reg(directed[i].reg_index, directed[i].reg_data);
                end
                default:
                    tick_until_idle();
            endcase
        end

        // --- random traffic: four idling modes, two register settings each ---
        for (int sub = 0; sub < SUBPHASES; sub++)
        begin
            settle();
            case (sub / 2)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 45; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 8;  stall_pct = 8;  end
            endcase
            // mostly one-tick phases so many bursts complete
            write_reg(REG_SHORT_TICKS, CFG_DATA_W'($urandom_range(2)));
            write_reg(REG_LONG_TICKS, CFG_DATA_W'($urandom_range(3)));
            write_reg(REG_SYNC_LOW_TICKS, CFG_DATA_W'($urandom_range(4)));
            write_reg(REG_REPEAT_COUNT, CFG_DATA_W'($urandom_range(3, 1)));

            counted = 0;
            while (counted < RANDOM_TARGET / SUBPHASES)
            begin
                c = mk_cmd(OP_TICK, 2'($urandom), 2'($urandom), 2'($urandom));
                was_active = enc_active;
                // well-formed: start from idle, tick through the burst;
                // some idle ticks and stray starts mid-burst as noise
                if (was_active)
                begin
                    if ($urandom_range(19) == 0)
                        c.opcode = OP_START;
                end
                else if ($urandom_range(9) != 0)
                    c.opcode = OP_START;
                if (was_active == (c.opcode == OP_TICK))
                    counted++;
                push_cmd(c, 1'b0, RSP_IDLE);
            end
            tick_until_idle();
        end

        send_idle_pct = 0;
        stall_pct = 0;
        settle();

        $display("Covered %0d command transactions, %0d register writes, %0d bursts completed",
                 items_sent, writes_done, bursts_seen);
        $display("Idling modes: none, sender 45%%, receiver 45%%, both 8%%; errors: %0d",
                 errors);
        if (errors == 0)
            $display("tristate_remote_frame_encoder_unit: match");
        else
            $display("tristate_remote_frame_encoder_unit: mismatch");
        $finish;
    end

endmodule
